// ----- design/matrix_row_column_swap_remap_defines.svh -----
// Assertion macros shared by the matrix row/column remap design
`ifndef MATRIX_ROW_COLUMN_SWAP_REMAP_DEFINES_SVH
`define MATRIX_ROW_COLUMN_SWAP_REMAP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define MRCSR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define MRCSR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ----- design/mrcsr_pkg.sv -----
// Types and constants shared by the matrix row/column remap design
`timescale 1ns / 1ps

package mrcsr_pkg;

    localparam int IDX_W     = 8;
    localparam int VAL_W     = 32;
    localparam int OP_W      = 2;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int IDX_SPAN  = 2 ** IDX_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(IDX_SPAN);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD     = 2'd0,
        OP_GET      = 2'd1,
        OP_SWAP_ROW = 2'd2,
        OP_SWAP_COL = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CMD_LOAD,
        CMD_GET,
        CMD_GET_ERR,
        CMD_SWAP_ROW,
        CMD_SWAP_COL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [IDX_W-1:0]   first;
        logic [IDX_W-1:0]   second;
        logic [VAL_W-1:0]   value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- design/matrix_row_column_swap_remap.sv -----
// Top level of the matrix store behind row and column permutation maps
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready    | op, first_index, second_index,
//          |           |                        | entry_value
//  out     | out       | out_valid / out_ready  | read_value, index_error
//
// The front end takes one word per cycle while the two-entry queue has room.
// In the back end a load is one write from idle, a get steps through map read, matrix read and result
// register, and a swap through map read, then two writes through the map's one write port.
// Maps come out of reset as identity through per-entry valid flops; the matrix
// store holds nothing defined until loaded. There is no clearing pass.
// A result left waiting holds the get in its last cycle; later words queue behind it.
`timescale 1ns / 1ps

module matrix_row_column_swap_remap #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLS    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mrcsr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mrcsr_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mrcsr_pkg::OP_W-1:0]          op,
    input  logic [mrcsr_pkg::IDX_W-1:0]         first_index,
    input  logic [mrcsr_pkg::IDX_W-1:0]         second_index,
    input  logic signed [mrcsr_pkg::VAL_W-1:0]  entry_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mrcsr_pkg::VAL_W-1:0]  read_value,
    output logic                                index_error
);

    // Indices are 8 bits wide, so no more than 256 rows or columns are reachable
    localparam int ROW_N = (MAX_ROWS < mrcsr_pkg::IDX_SPAN) ? MAX_ROWS : mrcsr_pkg::IDX_SPAN;
    localparam int COL_N = (MAX_COLS < mrcsr_pkg::IDX_SPAN) ? MAX_COLS : mrcsr_pkg::IDX_SPAN;

    logic                 push, pop;
    mrcsr_pkg::cmd_t      push_cmd, head_cmd;
    mrcsr_pkg::q_status_t q_status;

    mrcsr_front #(.ROW_N(ROW_N), .COL_N(COL_N)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .first_index  (first_index),
        .second_index (second_index),
        .entry_value  (entry_value),
        .q_status     (q_status),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    mrcsr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_status (q_status)
    );

    mrcsr_back #(
        .ROW_N       (ROW_N),
        .COL_N       (COL_N),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .cmd         (head_cmd),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .index_error (index_error)
    );

endmodule

// ----- design/mrcsr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data
`timescale 1ns / 1ps

module mrcsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/mrcsr_front.sv -----
// Front end: configuration registers, index checks and command classification
`timescale 1ns / 1ps

module mrcsr_front #(
    parameter int ROW_N = 256,
    parameter int COL_N = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mrcsr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mrcsr_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mrcsr_pkg::OP_W-1:0]          op,
    input  logic [mrcsr_pkg::IDX_W-1:0]         first_index,
    input  logic [mrcsr_pkg::IDX_W-1:0]         second_index,
    input  logic [mrcsr_pkg::VAL_W-1:0]         entry_value,
    input  mrcsr_pkg::q_status_t                q_status,
    output logic                                push,
    output mrcsr_pkg::cmd_t                     push_cmd
);

    localparam logic [mrcsr_pkg::CFG_W-1:0] ROW_LIM = mrcsr_pkg::CFG_W'(ROW_N);
    localparam logic [mrcsr_pkg::CFG_W-1:0] COL_LIM = mrcsr_pkg::CFG_W'(COL_N);

    logic [mrcsr_pkg::CFG_W-1:0] rows_in_use_reg, rows_in_use_next;
    logic [mrcsr_pkg::CFG_W-1:0] cols_in_use_reg, cols_in_use_next;
    logic [mrcsr_pkg::CFG_W-1:0] a_ext, b_ext;
    logic a_row_ok, b_row_ok, a_col_ok, b_col_ok;
    logic accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_status.full;
    assign accept    = in_valid && in_ready;

    assign a_ext = {1'b0, first_index};
    assign b_ext = {1'b0, second_index};

    // An index is good only below both the register and the built size
    assign a_row_ok = (a_ext < rows_in_use_reg) && (a_ext < ROW_LIM);
    assign b_row_ok = (b_ext < rows_in_use_reg) && (b_ext < ROW_LIM);
    assign a_col_ok = (a_ext < cols_in_use_reg) && (a_ext < COL_LIM);
    assign b_col_ok = (b_ext < cols_in_use_reg) && (b_ext < COL_LIM);

    always_comb
    begin
        rows_in_use_next = rows_in_use_reg;
        cols_in_use_next = cols_in_use_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (mrcsr_pkg::cfg_reg_t'(cfg_index))
                mrcsr_pkg::CFG_ROWS: rows_in_use_next = cfg_data;
                mrcsr_pkg::CFG_COLS: cols_in_use_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= mrcsr_pkg::CFG_RESET;
            cols_in_use_reg <= mrcsr_pkg::CFG_RESET;
        end
        else
        begin
            rows_in_use_reg <= rows_in_use_next;
            cols_in_use_reg <= cols_in_use_next;
        end
    end

    // Classify the word; drop loads and swaps with a bad index
    always_comb
    begin
        push_cmd.first  = first_index;
        push_cmd.second = second_index;
        push_cmd.value  = entry_value;
        push_cmd.kind   = mrcsr_pkg::CMD_LOAD;
        push            = 1'b0;
        case (mrcsr_pkg::op_t'(op))
            mrcsr_pkg::OP_LOAD:
            begin
                push_cmd.kind = mrcsr_pkg::CMD_LOAD;
                push          = accept && a_row_ok && b_col_ok;
            end
            mrcsr_pkg::OP_GET:
            begin
                push_cmd.kind = (a_row_ok && b_col_ok) ? mrcsr_pkg::CMD_GET
                                                       : mrcsr_pkg::CMD_GET_ERR;
                push          = accept;
            end
            mrcsr_pkg::OP_SWAP_ROW:
            begin
                push_cmd.kind = mrcsr_pkg::CMD_SWAP_ROW;
                push          = accept && a_row_ok && b_row_ok;
            end
            mrcsr_pkg::OP_SWAP_COL:
            begin
                push_cmd.kind = mrcsr_pkg::CMD_SWAP_COL;
                push          = accept && a_col_ok && b_col_ok;
            end
            default: ;
        endcase
    end

endmodule

// ----- design/mrcsr_queue.sv -----
// Two-entry command queue between the front end and the back end
`timescale 1ns / 1ps

module mrcsr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mrcsr_pkg::cmd_t      push_cmd,
    input  logic                 pop,
    output mrcsr_pkg::cmd_t      head_cmd,
    output mrcsr_pkg::q_status_t q_status
);

    localparam logic [mrcsr_pkg::QUEUE_AW:0] FULL_COUNT =
        (mrcsr_pkg::QUEUE_AW + 1)'(mrcsr_pkg::QUEUE_DEPTH);

    mrcsr_pkg::cmd_t                  entries_reg [mrcsr_pkg::QUEUE_DEPTH];
    logic [mrcsr_pkg::QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [mrcsr_pkg::QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [mrcsr_pkg::QUEUE_AW:0]     count_reg, count_next;
    logic do_push, do_pop;

    assign q_status.full  = (count_reg == FULL_COUNT);
    assign q_status.empty = (count_reg == '0);
    assign head_cmd       = entries_reg[rd_ptr_reg];

    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- design/mrcsr_back.sv -----
// Back end: permutation maps, matrix store, command sequencer and result register
`timescale 1ns / 1ps
`include "matrix_row_column_swap_remap_defines.svh"

module mrcsr_back #(
    parameter int ROW_N       = 256,
    parameter int COL_N       = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mrcsr_pkg::q_status_t                q_status,
    input  mrcsr_pkg::cmd_t                     cmd,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mrcsr_pkg::VAL_W-1:0]  read_value,
    output logic                                index_error
);

    localparam int ROW_AW    = $clog2(ROW_N);
    localparam int COL_AW    = $clog2(COL_N);
    localparam int MAP_W     = (ROW_AW > COL_AW) ? ROW_AW : COL_AW;
    localparam int MEM_DEPTH = ROW_N * COL_N;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int VAL_W     = mrcsr_pkg::VAL_W;
    localparam int IDX_W     = mrcsr_pkg::IDX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GET_MAP,
        ST_GET_MEM,
        ST_SWAP_RD,
        ST_SWAP_WR
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0] first_reg, first_next;
    logic [IDX_W-1:0] second_reg, second_next;
    logic             swap_col_reg, swap_col_next;
    logic [MAP_W-1:0] hold_reg, hold_next;
    logic [ROW_N-1:0] row_valid_reg, row_valid_next;
    logic [COL_N-1:0] col_valid_reg, col_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic [VAL_W-1:0] read_value_reg, read_value_next;
    logic             index_error_reg, index_error_next;

    // Map RAMs: two copies each so a swap reads both entries in the same cycle
    logic              row_we, col_we;
    logic [ROW_AW-1:0] row_waddr, row_wdata;
    logic [COL_AW-1:0] col_waddr, col_wdata;
    logic              row0_re, row1_re, col0_re, col1_re;
    logic [ROW_AW-1:0] row0_raddr, row1_raddr, row0_rdata, row1_rdata;
    logic [COL_AW-1:0] col0_raddr, col1_raddr, col0_rdata, col1_rdata;

    logic                   mem_we, mem_re;
    logic [MEM_AW-1:0]      mem_waddr, mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;
    logic [VAL_W-1:0]       mem_rd_ext;

    logic [IDX_W-1:0]  col0_idx;
    logic [ROW_AW-1:0] row_a_map, row_b_map;
    logic [COL_AW-1:0] col0_map, col_b_map;
    logic              out_free;

    mrcsr_ram #(.WIDTH(ROW_AW), .DEPTH(ROW_N)) u_row_map0 (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row0_re),
        .raddr (row0_raddr),
        .rdata (row0_rdata)
    );

    mrcsr_ram #(.WIDTH(ROW_AW), .DEPTH(ROW_N)) u_row_map1 (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row1_re),
        .raddr (row1_raddr),
        .rdata (row1_rdata)
    );

    mrcsr_ram #(.WIDTH(COL_AW), .DEPTH(COL_N)) u_col_map0 (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .re    (col0_re),
        .raddr (col0_raddr),
        .rdata (col0_rdata)
    );

    mrcsr_ram #(.WIDTH(COL_AW), .DEPTH(COL_N)) u_col_map1 (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .re    (col1_re),
        .raddr (col1_raddr),
        .rdata (col1_rdata)
    );

    mrcsr_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MEM_DEPTH)) u_matrix (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Stored width versus port width: sign-extend on load, zero-extend on read
    generate
        if (VALUE_WIDTH > VAL_W)
        begin : g_wide
            assign mem_wdata  = {{(VALUE_WIDTH - VAL_W){cmd.value[VAL_W-1]}}, cmd.value};
            assign mem_rd_ext = mem_rdata[VAL_W-1:0];
        end
        else if (VALUE_WIDTH == VAL_W)
        begin : g_same
            assign mem_wdata  = cmd.value;
            assign mem_rd_ext = mem_rdata;
        end
        else
        begin : g_narrow
            assign mem_wdata  = cmd.value[VALUE_WIDTH-1:0];
            assign mem_rd_ext = {{(VAL_W - VALUE_WIDTH){1'b0}}, mem_rdata};
        end
    endgenerate

    assign row0_raddr = cmd.first[ROW_AW-1:0];
    assign row1_raddr = cmd.second[ROW_AW-1:0];
    assign col0_raddr = (cmd.kind == mrcsr_pkg::CMD_SWAP_COL) ? cmd.first[COL_AW-1:0]
                                                              : cmd.second[COL_AW-1:0];
    assign col1_raddr = cmd.second[COL_AW-1:0];
    assign mem_waddr  = MEM_AW'(cmd.first[ROW_AW-1:0]) * MEM_AW'(COL_N)
                      + MEM_AW'(cmd.second[COL_AW-1:0]);

    // An entry never written still holds its own index
    assign col0_idx  = swap_col_reg ? first_reg : second_reg;
    assign row_a_map = row_valid_reg[first_reg[ROW_AW-1:0]] ? row0_rdata
                                                            : first_reg[ROW_AW-1:0];
    assign row_b_map = row_valid_reg[second_reg[ROW_AW-1:0]] ? row1_rdata
                                                             : second_reg[ROW_AW-1:0];
    assign col0_map  = col_valid_reg[col0_idx[COL_AW-1:0]] ? col0_rdata
                                                           : col0_idx[COL_AW-1:0];
    assign col_b_map = col_valid_reg[second_reg[COL_AW-1:0]] ? col1_rdata
                                                             : second_reg[COL_AW-1:0];
    assign mem_raddr = MEM_AW'(row_a_map) * MEM_AW'(COL_N) + MEM_AW'(col0_map);

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next       = state_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        swap_col_next    = swap_col_reg;
        hold_next        = hold_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        read_value_next  = read_value_reg;
        index_error_next = index_error_reg;
        pop       = 1'b0;
        row0_re   = 1'b0;
        row1_re   = 1'b0;
        col0_re   = 1'b0;
        col1_re   = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        row_we    = 1'b0;
        col_we    = 1'b0;
        row_waddr = first_reg[ROW_AW-1:0];
        row_wdata = row_b_map;
        col_waddr = first_reg[COL_AW-1:0];
        col_wdata = col_b_map;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    first_next    = cmd.first;
                    second_next   = cmd.second;
                    swap_col_next = (cmd.kind == mrcsr_pkg::CMD_SWAP_COL);
                    case (cmd.kind)
                        mrcsr_pkg::CMD_LOAD:
                        begin
                            mem_we = 1'b1;
                            pop    = 1'b1;
                        end
                        mrcsr_pkg::CMD_GET_ERR:
                        begin
                            if (out_free)
                            begin
                                pop              = 1'b1;
                                out_valid_next   = 1'b1;
                                read_value_next  = '0;
                                index_error_next = 1'b1;
                            end
                        end
                        mrcsr_pkg::CMD_GET:
                        begin
                            pop        = 1'b1;
                            row0_re    = 1'b1;
                            col0_re    = 1'b1;
                            state_next = ST_GET_MAP;
                        end
                        mrcsr_pkg::CMD_SWAP_ROW:
                        begin
                            pop        = 1'b1;
                            row0_re    = 1'b1;
                            row1_re    = 1'b1;
                            state_next = ST_SWAP_RD;
                        end
                        mrcsr_pkg::CMD_SWAP_COL:
                        begin
                            pop        = 1'b1;
                            col0_re    = 1'b1;
                            col1_re    = 1'b1;
                            state_next = ST_SWAP_RD;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_GET_MAP:
            begin
                mem_re     = 1'b1;
                state_next = ST_GET_MEM;
            end
            ST_GET_MEM:
            begin
                // Hold here until the result register frees up
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    read_value_next  = mem_rd_ext;
                    index_error_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            ST_SWAP_RD:
            begin
                if (swap_col_reg)
                begin
                    col_we    = 1'b1;
                    hold_next = MAP_W'(col0_map);
                end
                else
                begin
                    row_we    = 1'b1;
                    hold_next = MAP_W'(row_a_map);
                end
                state_next = ST_SWAP_WR;
            end
            ST_SWAP_WR:
            begin
                row_waddr = second_reg[ROW_AW-1:0];
                row_wdata = hold_reg[ROW_AW-1:0];
                col_waddr = second_reg[COL_AW-1:0];
                col_wdata = hold_reg[COL_AW-1:0];
                row_we    = !swap_col_reg;
                col_we    = swap_col_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        row_valid_next = row_valid_reg;
        col_valid_next = col_valid_reg;
        if (row_we)
        begin
            row_valid_next[row_waddr] = 1'b1;
        end
        if (col_we)
        begin
            col_valid_next[col_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            first_reg       <= '0;
            second_reg      <= '0;
            swap_col_reg    <= 1'b0;
            hold_reg        <= '0;
            row_valid_reg   <= '0;
            col_valid_reg   <= '0;
            out_valid_reg   <= 1'b0;
            read_value_reg  <= '0;
            index_error_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            first_reg       <= first_next;
            second_reg      <= second_next;
            swap_col_reg    <= swap_col_next;
            hold_reg        <= hold_next;
            row_valid_reg   <= row_valid_next;
            col_valid_reg   <= col_valid_next;
            out_valid_reg   <= out_valid_next;
            read_value_reg  <= read_value_next;
            index_error_reg <= index_error_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign index_error = index_error_reg;

    `MRCSR_ASSERT_IMP(a_pop_not_empty, pop, !q_status.empty)
    `MRCSR_ASSERT_NXT(a_get_map_then_mem, state_reg == ST_GET_MAP, state_reg == ST_GET_MEM)
    `MRCSR_ASSERT_NXT(a_swap_second_write, state_reg == ST_SWAP_RD,
                      state_reg == ST_SWAP_WR && (row_we || col_we))
    `MRCSR_ASSERT_IMP(a_load_only_idle, mem_we, state_reg == ST_IDLE && !mem_re)

endmodule
